// ===== hdl/match_self_coherence_score_unit_defines.svh =====
// Assertion macros shared by the match self coherence score unit
`ifndef MATCH_SELF_COHERENCE_SCORE_UNIT_DEFINES_SVH
`define MATCH_SELF_COHERENCE_SCORE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define MSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/msc_pkg.sv =====
// Shared widths, register indexes and bundle types of the self coherence score unit
package msc_pkg;

  localparam int FRAC_BITS = 14;
  localparam int AREA_W    = 22;
  localparam int COORD_W   = 16;
  localparam int TOL_W     = 16;
  localparam int EV_W      = 16;
  localparam int RFRAC     = 16;
  localparam int RATIO_QW  = TOL_W + 10;
  localparam int QUO_W     = FRAC_BITS + 2;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int ROOT_W    = COORD_W + 9;
  localparam int CFG_W     = AREA_W;
  localparam int IDX_W     = 2;

  localparam logic [IDX_W-1:0] REG_NOISE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIZE_TOL = 2'd1;
  localparam logic [IDX_W-1:0] REG_POS_TOL  = 2'd2;

  localparam logic [AREA_W-1:0] NOISE_RST    = 22'd3072;
  localparam logic [TOL_W-1:0]  SIZE_TOL_RST = 16'd256;
  localparam logic [TOL_W-1:0]  POS_TOL_RST  = 16'd5120;

  typedef struct packed {
    logic [AREA_W-1:0] num;
    logic [AREA_W:0]   den;
    logic              num_pos;
    logic [SQ_W-1:0]   dx2;
    logic [SQ_W-1:0]   dy2;
  } front_t;

endpackage

// ===== hdl/msc_front.sv =====
// Front stages: area ratio operands, coordinate deltas and their squares
module msc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [msc_pkg::AREA_W-1:0]  noise_area,
  input  logic [msc_pkg::AREA_W-1:0]  landmark_area,
  input  logic [msc_pkg::COORD_W-1:0] landmark_x,
  input  logic [msc_pkg::COORD_W-1:0] landmark_y,
  input  logic [msc_pkg::AREA_W-1:0]  object_area,
  input  logic [msc_pkg::COORD_W-1:0] object_x,
  input  logic [msc_pkg::COORD_W-1:0] object_y,
  output logic                        out_valid,
  output msc_pkg::front_t             out
);
  import msc_pkg::*;

  logic signed [AREA_W+1:0]  diff;
  logic                      land_big;
  logic [AREA_W-1:0]         num_c;
  logic [AREA_W:0]           den_c;
  logic                      pos_c;
  logic signed [COORD_W:0]   dx_c;
  logic signed [COORD_W:0]   dy_c;

  logic                      v1;
  logic [AREA_W-1:0]         num1;
  logic [AREA_W:0]           den1;
  logic                      pos1;
  logic signed [COORD_W:0]   dx1;
  logic signed [COORD_W:0]   dy1;
  logic signed [2*COORD_W+1:0] dxs;
  logic signed [2*COORD_W+1:0] dys;

  // pick numerator and divisor by which area is larger
  always_comb begin
    diff     = $signed({2'b00, landmark_area}) - $signed({2'b00, noise_area});
    land_big = landmark_area > object_area;
    if (land_big) begin
      num_c = diff[AREA_W-1:0];
      pos_c = diff > 0;
      den_c = {1'b0, object_area};
    end else begin
      num_c = object_area;
      pos_c = object_area != '0;
      den_c = {1'b0, landmark_area} + {1'b0, noise_area};
    end
    dx_c = $signed({landmark_x[COORD_W-1], landmark_x})
         - $signed({object_x[COORD_W-1], object_x});
    dy_c = $signed({landmark_y[COORD_W-1], landmark_y})
         - $signed({object_y[COORD_W-1], object_y});
  end

  assign dxs = dx1 * dx1;
  assign dys = dy1 * dy1;

  // first stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  // first stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      num1 <= num_c;
      den1 <= den_c;
      pos1 <= pos_c;
      dx1  <= dx_c;
      dy1  <= dy_c;
    end
  end

  // second stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  // second stage: squares of the deltas
  always_ff @(posedge clk) begin
    if (en) begin
      out.num     <= num1;
      out.den     <= den1;
      out.num_pos <= pos1;
      out.dx2     <= dxs[SQ_W-1:0];
      out.dy2     <= dys[SQ_W-1:0];
    end
  end

endmodule

// ===== hdl/msc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
module msc_div #(
  parameter int NUM_W  = 38,
  parameter int DEN_W  = 23,
  parameter int QW     = 26,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QW-1:0]     quo,
  output logic              sat,
  output logic [SIDE_W-1:0] side_out
);
  localparam int W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;

  logic [W-1:0]      rem [0:QW-1];
  logic [DEN_W-1:0]  dv  [0:QW-1];
  logic [QW-1:0]     q   [0:QW];
  logic              s   [0:QW];
  logic              v   [0:QW];
  logic [SIDE_W-1:0] sd  [0:QW];

  // entry stage: flag quotients that do not fit
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W'(num);
      dv[0]  <= den;
      q[0]   <= '0;
      s[0]   <= W'(num) >= (W'(den) << QW);
      sd[0]  <= side_in;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [W-1:0] trial;
    logic         ge;

    assign trial = W'(dv[j]) << K;
    assign ge    = rem[j] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    // lower bits are still zero here, so set bit K by an or
    always_ff @(posedge clk) begin
      if (en) begin
        q[j+1]  <= q[j] | (QW'(ge) << K);
        s[j+1]  <= s[j];
        sd[j+1] <= sd[j];
      end
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? rem[j] - trial : rem[j];
          dv[j+1]  <= dv[j];
        end
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = q[QW];
  assign sat       = s[QW];
  assign side_out  = sd[QW];

endmodule

// ===== hdl/msc_sqrt.sv =====
// Pipelined integer square root of the scaled squared distance, one root bit per stage
module msc_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [msc_pkg::SQ_W-1:0]   dx2,
  input  logic [msc_pkg::SQ_W-1:0]   dy2,
  output logic                       out_valid,
  output logic [msc_pkg::ROOT_W-1:0] root
);
  import msc_pkg::*;

  localparam int R = 2 * ROOT_W;

  logic [R-1:0]      rem [0:ROOT_W-1];
  logic [ROOT_W-1:0] rt  [0:ROOT_W];
  logic              v   [0:ROOT_W];
  logic [SQ_W:0]     sq;

  assign sq = {1'b0, dx2} + {1'b0, dy2};

  // entry stage: sum of squares in Q.8 squared
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= R'({sq, 16'b0});
      rt[0]  <= '0;
    end
  end

  // settle one root bit per stage
  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int B = ROOT_W - 1 - j;
    logic [R-1:0] cand;
    logic         ge;

    assign cand = (R'(rt[j]) << (B + 1)) | (R'(1) << (2 * B));
    assign ge   = rem[j] >= cand;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    // lower root bits are still zero here, so set bit B by an or
    always_ff @(posedge clk) begin
      if (en) begin
        rt[j+1] <= rt[j] | (ROOT_W'(ge) << B);
      end
    end

    if (j < ROOT_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j+1] <= ge ? rem[j] - cand : rem[j];
        end
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign root      = rt[ROOT_W];

endmodule

// ===== hdl/match_self_coherence_score_unit.sv =====
// Throughput: one request per cycle while the output is not stalled; the depth comes from the bit-per-stage ratio
// divider (27 stages) followed by the size divider (17 stages), with the square root
// and position divider running alongside.
// Reset: synchronous, clears all valid bits and restores the register defaults.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
`include "match_self_coherence_score_unit_defines.svh"

module match_self_coherence_score_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [msc_pkg::IDX_W-1:0]           cfg_index,
  input  logic [msc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [msc_pkg::AREA_W-1:0]          landmark_area,
  input  logic signed [msc_pkg::COORD_W-1:0]  landmark_x,
  input  logic signed [msc_pkg::COORD_W-1:0]  landmark_y,
  input  logic [msc_pkg::AREA_W-1:0]          object_area,
  input  logic signed [msc_pkg::COORD_W-1:0]  object_x,
  input  logic signed [msc_pkg::COORD_W-1:0]  object_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [msc_pkg::EV_W-1:0]     score
);
  import msc_pkg::*;

  localparam int EVW = FRAC_BITS + 4;
  localparam logic [RATIO_QW-1:0] RATIO_ONE = RATIO_QW'(1) << RFRAC;
  localparam logic signed [EVW-1:0] ONE_E   = EVW'(1) << FRAC_BITS;
  localparam logic signed [EV_W-1:0] EV_ONE = EV_W'(1) << FRAC_BITS;

  logic [AREA_W-1:0] noise_area;
  logic [TOL_W-1:0]  size_tol;
  logic [TOL_W-1:0]  pos_tol;
  logic              en;

  front_t            fr;
  logic              fr_valid;

  logic              rdiv_valid;
  logic [RATIO_QW-1:0] ratio_q;
  logic              ratio_sat;
  logic              ratio_pos;

  logic [RATIO_QW-1:0] r1;
  logic [1:0]        size_side_in;

  logic              sdiv_valid;
  logic [QUO_W-1:0]  size_q;
  logic              size_sat;
  logic [1:0]        size_side;

  logic              sqrt_valid;
  logic [ROOT_W-1:0] dist_root;
  logic              dly_valid;
  logic [ROOT_W-1:0] dly_dist;

  logic              pdiv_valid;
  logic [QUO_W-1:0]  pos_q;
  logic              pos_sat;
  logic              pos_zero;

  logic signed [EVW-1:0] size_ev;
  logic signed [EVW-1:0] pos_ev;
  logic signed [EVW-1:0] min_ev;
  logic signed [EVW-1:0] ev_c;

  // advance the whole pipe unless the output is held
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_area <= NOISE_RST;
      size_tol   <= SIZE_TOL_RST;
      pos_tol    <= POS_TOL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NOISE:    noise_area <= cfg_data[AREA_W-1:0];
        REG_SIZE_TOL: size_tol   <= cfg_data[TOL_W-1:0];
        REG_POS_TOL:  pos_tol    <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  msc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (in_valid),
    .noise_area    (noise_area),
    .landmark_area (landmark_area),
    .landmark_x    (landmark_x),
    .landmark_y    (landmark_y),
    .object_area   (object_area),
    .object_x      (object_x),
    .object_y      (object_y),
    .out_valid     (fr_valid),
    .out           (fr)
  );

  // area ratio in Q10.16
  msc_div #(
    .NUM_W  (AREA_W + RFRAC),
    .DEN_W  (AREA_W + 1),
    .QW     (RATIO_QW),
    .SIDE_W (1)
  ) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .num       ({fr.num, RFRAC'(0)}),
    .den       (fr.den),
    .side_in   (fr.num_pos),
    .out_valid (rdiv_valid),
    .quo       (ratio_q),
    .sat       (ratio_sat),
    .side_out  (ratio_pos)
  );

  // ratio minus one, floored at zero; a huge ratio saturates the size term
  always_comb begin
    if (ratio_pos && !ratio_sat && ratio_q > RATIO_ONE) begin
      r1 = ratio_q - RATIO_ONE;
    end else begin
      r1 = '0;
    end
    size_side_in = {ratio_pos && ratio_sat, r1 == '0};
  end

  msc_div #(
    .NUM_W  (RATIO_QW + FRAC_BITS),
    .DEN_W  (TOL_W + 8),
    .QW     (QUO_W),
    .SIDE_W (2)
  ) u_size_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rdiv_valid),
    .num       ({r1, FRAC_BITS'(0)}),
    .den       ({size_tol, 8'b0}),
    .side_in   (size_side_in),
    .out_valid (sdiv_valid),
    .quo       (size_q),
    .sat       (size_sat),
    .side_out  (size_side)
  );

  msc_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .dx2       (fr.dx2),
    .dy2       (fr.dy2),
    .out_valid (sqrt_valid),
    .root      (dist_root)
  );

  // hold the distance one stage to line up with the size lane
  always_ff @(posedge clk) begin
    if (rst) begin
      dly_valid <= 1'b0;
    end else if (en) begin
      dly_valid <= sqrt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_dist <= dist_root;
    end
  end

  msc_div #(
    .NUM_W  (ROOT_W + FRAC_BITS),
    .DEN_W  (TOL_W),
    .QW     (QUO_W),
    .SIDE_W (1)
  ) u_pos_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dly_valid),
    .num       ({dly_dist, FRAC_BITS'(0)}),
    .den       (pos_tol),
    .side_in   (dly_dist == '0),
    .out_valid (pdiv_valid),
    .quo       (pos_q),
    .sat       (pos_sat),
    .side_out  (pos_zero)
  );

  // evidences, minimum and clamp
  always_comb begin
    if (size_side[1] || (!size_side[0] && size_sat)) begin
      size_ev = -ONE_E;
    end else if (size_side[0]) begin
      size_ev = ONE_E;
    end else begin
      size_ev = ONE_E - $signed({2'b00, size_q});
    end
    if (pos_zero) begin
      pos_ev = ONE_E;
    end else if (pos_sat) begin
      pos_ev = -ONE_E;
    end else begin
      pos_ev = ONE_E - $signed({2'b00, pos_q});
    end
    min_ev = (size_ev < pos_ev) ? size_ev : pos_ev;
    ev_c   = (min_ev < -ONE_E) ? -ONE_E : min_ev;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= sdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      score <= ev_c[EV_W-1:0];
    end
  end

  `MSC_ASSERT_NOW(a_lanes_aligned, 1'b1, sdiv_valid == pdiv_valid, "size and position lanes out of step")
  `MSC_ASSERT_NOW(a_ev_range, out_valid, (score >= -EV_ONE) && (score <= EV_ONE), "score outside [-1, 1]")
  `MSC_ASSERT_NOW(a_accept_when_empty, !out_valid, !in_stall, "input stalled with empty output")
  `MSC_ASSERT_NEXT(a_enter_pipe, in_valid && !in_stall, u_front.v1, "accepted request not captured")

endmodule

// ===== dv/match_self_coherence_score_checker.sv =====
// Checker that predicts and compares self evidence results of the score unit
`timescale 1ns / 100ps

module match_self_coherence_score_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [msc_pkg::IDX_W-1:0]           cfg_index,
  input  logic [msc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [msc_pkg::AREA_W-1:0]          landmark_area,
  input  logic signed [msc_pkg::COORD_W-1:0]  landmark_x,
  input  logic signed [msc_pkg::COORD_W-1:0]  landmark_y,
  input  logic [msc_pkg::AREA_W-1:0]          object_area,
  input  logic signed [msc_pkg::COORD_W-1:0]  object_x,
  input  logic signed [msc_pkg::COORD_W-1:0]  object_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [msc_pkg::EV_W-1:0]     score,
  output int                                  errors,
  output int                                  pending
);
  import msc_pkg::*;

  logic [AREA_W-1:0] noise_q;
  logic [TOL_W-1:0]  size_tol_q;
  logic [TOL_W-1:0]  pos_tol_q;
  logic signed [EV_W-1:0] evidence_q[$];

  assign pending = evidence_q.size();

  // Bitwise integer square root
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Saturating quotient in Q.FRAC_BITS
  function automatic longint sat_quot(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint limit;
    limit = longint'(4) << FRAC_BITS;
    if (den == 0) return (num == 0) ? 0 : limit;
    q = num / den;
    if (q > longint'(limit)) return limit;
    return longint'(q);
  endfunction

  function automatic logic signed [EV_W-1:0] predict_evidence(
    longint la, longint lx, longint ly, longint oa, longint ox, longint oy);
    longint num, den, one, size_ev, pos_ev, ev, dx, dy;
    longint unsigned ratio, sq, root_d;
    if (la > oa) begin
      num = la - longint'(noise_q);
      den = oa;
    end else begin
      num = oa;
      den = la + longint'(noise_q);
    end
    if (num <= 0) ratio = 64'd65536;
    else if (den == 0) ratio = 64'hFFFF_FFFF;
    else begin
      ratio = ($unsigned(num) << 16) / $unsigned(den);
      if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
    end
    if (ratio < 64'd65536) ratio = 64'd65536;
    one = longint'(1) << FRAC_BITS;
    size_ev = one - sat_quot((ratio - 64'd65536) << FRAC_BITS,
                             64'(size_tol_q) << 8);
    dx = lx - ox;
    dy = ly - oy;
    sq = $unsigned(dx * dx) + $unsigned(dy * dy);
    root_d = int_sqrt(sq << 16);
    pos_ev = one - sat_quot(root_d << FRAC_BITS, 64'(pos_tol_q));
    ev = (size_ev < pos_ev) ? size_ev : pos_ev;
    if (ev > one) ev = one;
    if (ev < -one) ev = -one;
    return ev[EV_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [EV_W-1:0] want;
    if (rst) begin
      noise_q    <= NOISE_RST;
      size_tol_q <= SIZE_TOL_RST;
      pos_tol_q  <= POS_TOL_RST;
      evidence_q.delete();
      errors     <= 0;
    end else begin
      // Track register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_NOISE:    noise_q    <= cfg_data[AREA_W-1:0];
          REG_SIZE_TOL: size_tol_q <= cfg_data[TOL_W-1:0];
          REG_POS_TOL:  pos_tol_q  <= cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      // Predict each accepted request
      if (in_valid && !in_stall)
        evidence_q.push_back(predict_evidence(longint'(landmark_area),
                                              longint'(landmark_x),
                                              longint'(landmark_y),
                                              longint'(object_area),
                                              longint'(object_x),
                                              longint'(object_y)));
      // Compare each accepted result
      if (out_valid && !out_stall) begin
        if (evidence_q.size() == 0) begin
          $display("%0t: unexpected result %0d", $time, score);
          errors <= errors + 1;
        end else begin
          want = evidence_q.pop_front();
          if (want !== score) begin
            $display("%0t: score expected %0d actual %0d", $time, want, score);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/match_self_coherence_score_unit_tb.sv =====
// Testbench top: stimulus, register phases and verdict for the score unit
`timescale 1ns / 100ps

module match_self_coherence_score_unit_tb;
  import msc_pkg::*;

  localparam int LATENCY    = 47;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_LEN   = 200;
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [AREA_W-1:0] landmark_area;
  logic signed [COORD_W-1:0] landmark_x;
  logic signed [COORD_W-1:0] landmark_y;
  logic [AREA_W-1:0] object_area;
  logic signed [COORD_W-1:0] object_x;
  logic signed [COORD_W-1:0] object_y;
  logic out_valid;
  logic out_stall;
  logic signed [EV_W-1:0] score;
  int errors;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_go;
  bit hold_done = 1'b0;
  int hold_cycles = 0;
  int cycle_count = 0;

  match_self_coherence_score_unit i_dut (.*);

  match_self_coherence_score_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Drive receiver stall, with one long hold-off once requested
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_done) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
      if (hold_cycles == HOLD_LEN - 1) begin
        hold_done <= 1'b1;
      end
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait for every result, then let the pipe drain
  task automatic drain_pipe();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Offer one request and hold it until accepted
  task automatic send_match(input logic [AREA_W-1:0] la, input logic [15:0] lx,
                            input logic [15:0] ly, input logic [AREA_W-1:0] oa,
                            input logic [15:0] ox, input logic [15:0] oy);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    landmark_area <= la;
    landmark_x    <= lx;
    landmark_y    <= ly;
    object_area   <= oa;
    object_x      <= ox;
    object_y      <= oy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [AREA_W-1:0] rand_area();
    case ($urandom_range(4))
      0: return AREA_W'($urandom_range(4095));
      1: return AREA_W'($urandom_range(65535));
      2: return AREA_W'($urandom);
      3: return AREA_W'($urandom_range(3));
      default: return AREA_W'({AREA_W{1'b1}} - $urandom_range(3));
    endcase
  endfunction

  // Random burst of candidate matches, mostly near each other
  task automatic random_matches(input int count);
    logic [AREA_W-1:0] la;
    logic signed [15:0] lx, ly;
    int r;
    for (int k = 0; k < count; k++) begin
      la = rand_area();
      lx = 16'($urandom);
      ly = 16'($urandom);
      r = int'($urandom_range(3));
      if (r == 0)
        send_match(la, lx, ly, rand_area(), 16'($urandom), 16'($urandom));
      else if (r == 1)
        send_match(la, lx, ly, AREA_W'(la + $urandom_range(8191) - 4096),
                   16'(lx + $urandom_range(63) - 32), 16'(ly + $urandom_range(63) - 32));
      else
        send_match(la, lx, ly, AREA_W'(la + $urandom_range(255) - 128),
                   16'(lx + $urandom_range(7) - 4), 16'(ly + $urandom_range(7) - 4));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_NOISE;
    cfg_data = '0;
    in_valid = 1'b0;
    landmark_area = '0;
    landmark_x = '0;
    landmark_y = '0;
    object_area = '0;
    object_x = '0;
    object_y = '0;
    send_idle_pct = 17;
    recv_idle_pct = 68;
    hold_go = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests at reset settings
    send_match(22'd0, 16'sd0, 16'sd0, 22'd0, 16'sd0, 16'sd0);
    send_match(22'h3FFFFF, 16'sh7FFF, 16'sh7FFF, 22'd0, -16'sh8000, -16'sh8000);
    send_match(22'd0, -16'sh8000, 16'sh7FFF, 22'h3FFFFF, 16'sh7FFF, -16'sh8000);
    send_match(22'd1000, 16'sd3, 16'sd4, 22'd900, 16'sd0, 16'sd0);
    send_match(22'd5000, 16'sd10, 16'sd10, 22'd5000, 16'sd10, 16'sd10);
    send_match(22'd2000, 16'sd0, 16'sd0, 22'd1000, 16'sd1, 16'sd0);
    send_match(22'd100, 16'sd0, 16'sd0, 22'd4000, 16'sd20, 16'sd0);
    send_match(22'h3FFFFF, 16'sd0, 16'sd0, 22'h3FFFFF, 16'sd0, 16'sd0);
    in_valid <= 1'b0;
    drain_pipe();

    // Zero tolerances and zero noise
    write_reg(REG_NOISE, 22'd0);
    write_reg(REG_SIZE_TOL, 22'd0);
    write_reg(REG_POS_TOL, 22'd0);
    send_match(22'd0, 16'sd0, 16'sd0, 22'd0, 16'sd0, 16'sd0);
    send_match(22'd10, 16'sd0, 16'sd0, 22'd0, 16'sd0, 16'sd0);
    send_match(22'd10, 16'sd0, 16'sd0, 22'd10, 16'sd0, 16'sd1);
    send_match(22'd10, 16'sd0, 16'sd0, 22'd11, 16'sd0, 16'sd0);
    send_match(22'd0, 16'sd5, 16'sd5, 22'd7, 16'sd5, 16'sd5);
    in_valid <= 1'b0;
    drain_pipe();

    // Maximum settings, then an ignored index
    write_reg(REG_NOISE, 22'h3FFFFF);
    write_reg(REG_SIZE_TOL, 22'h00FFFF);
    write_reg(REG_POS_TOL, 22'h00FFFF);
    write_reg(REG_NONE, 22'h2AAAAA);
    send_match(22'h3FFFFF, 16'sd0, 16'sd0, 22'd1, 16'sh7FFF, 16'sh7FFF);
    send_match(22'd1, 16'sd0, 16'sd0, 22'h3FFFFF, -16'sd1, -16'sd1);
    send_match(22'd20, 16'sd0, 16'sd0, 22'd3, 16'sd0, 16'sd0);
    in_valid <= 1'b0;
    random_matches(150);
    drain_pipe();

    // Reset defaults, sender mostly active and receiver busy
    write_reg(REG_NOISE, CFG_W'(NOISE_RST));
    write_reg(REG_SIZE_TOL, CFG_W'(SIZE_TOL_RST));
    write_reg(REG_POS_TOL, CFG_W'(POS_TOL_RST));
    random_matches(400);

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct = 0;
    hold_go = 1'b1;
    random_matches(150);
    drain_pipe();

    // Swap idling, moderate settings
    send_idle_pct = 68;
    recv_idle_pct = 17;
    write_reg(REG_NOISE, CFG_W'($urandom_range(20000)));
    write_reg(REG_SIZE_TOL, CFG_W'($urandom_range(1, 2048)));
    write_reg(REG_POS_TOL, CFG_W'($urandom_range(1, 16384)));
    random_matches(400);
    drain_pipe();

    // No idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_NOISE, CFG_W'($urandom));
    write_reg(REG_SIZE_TOL, CFG_W'($urandom_range(1, 65535)));
    write_reg(REG_POS_TOL, CFG_W'($urandom_range(1, 65535)));
    random_matches(420);
    drain_pipe();

    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
